### sv/gct_pkg.sv
// Shared types, constants and helper functions for the geomagnetic coordinate transform.
// Used by gct_cordic and geomagnetic_coordinate_transform_core; depends on nothing else.
`default_nettype none

package gct_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 24;
  localparam int CORDIC_W        = 34;
  localparam int LAT_W           = 24;
  localparam int LON_W           = 25;
  localparam int CFG_W           = 25;
  localparam int SQRT_STEPS      = 31;

  typedef logic signed [CORDIC_W-1:0] cword_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_POLE_LAT = 1'b0,
    CFG_POLE_LON = 1'b1
  } cfg_index_t;

  // Status that rides along with one request through the back half of the pipeline.
  typedef struct packed {
    logic pole;
    logic degen;
    logic xneg;
    logic s_neg;
  } side_t;

  localparam logic signed [LAT_W-1:0] POLE_LAT_RESET = 24'sd5213389;
  localparam logic signed [LON_W-1:0] POLE_LON_RESET = -25'sd4690412;

  // Division by 45 through a reciprocal: floor(2^31 / 45), then one correction step.
  localparam logic [25:0] RECIP_45    = 26'd47721858;
  localparam int          TURN_SHIFT  = 32 - ANGLE_FRAC_BITS;
  localparam int          DEG_SHIFT   = TURN_SHIFT - 3;
  localparam logic [18:0] DEG_ROUND   = 19'd22;

  localparam cword_t CORDIC_GAIN = 34'sd652032874;
  localparam cword_t QUARTER     = 34'sd1073741824;
  localparam cword_t HALF        = 34'sd2147483648;

  localparam logic signed [28:0] MLAT_LIM = 29'sd90 <<< ANGLE_FRAC_BITS;
  localparam logic [24:0]        MLON_LIM = 25'd360 << ANGLE_FRAC_BITS;

  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Q30 product, rounded half up.
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

endpackage

`default_nettype wire

### sv/gct_cordic.sv
// Pipelined CORDIC, one micro-rotation per register stage, rotation or vectoring mode.
// Depends on gct_pkg for the word type and the arctangent table.
`default_nettype none

module gct_cordic #(
  parameter int STAGES    = gct_pkg::CORDIC_STAGES,
  parameter bit VECTORING = 1'b0
) (
  input  logic            clk,
  input  gct_pkg::cword_t x_in,
  input  gct_pkg::cword_t y_in,
  input  gct_pkg::cword_t z_in,
  output gct_pkg::cword_t x_out,
  output gct_pkg::cword_t y_out,
  output gct_pkg::cword_t z_out
);
  import gct_pkg::*;

  cword_t x_r [STAGES];
  cword_t y_r [STAGES];
  cword_t z_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam cword_t ATAN = {{(CORDIC_W-32){1'b0}}, atan_entry(i)};
    cword_t xp, yp, zp, x_nxt, y_nxt, z_nxt;
    logic   cw;

    if (i == 0) begin : g_first
      assign xp = x_in;
      assign yp = y_in;
      assign zp = z_in;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
    end

    // Rotation drives z to zero, vectoring drives y to zero.
    assign cw = VECTORING ? ~yp[CORDIC_W-1] : zp[CORDIC_W-1];

    always_comb begin
      if (cw) begin
        x_nxt = xp + (yp >>> i);
        y_nxt = yp - (xp >>> i);
        z_nxt = zp + ATAN;
      end else begin
        x_nxt = xp - (yp >>> i);
        y_nxt = yp + (xp >>> i);
        z_nxt = zp - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      x_r[i] <= x_nxt;
      y_r[i] <= y_nxt;
      z_r[i] <= z_nxt;
    end
  end

  assign x_out = x_r[STAGES-1];
  assign y_out = y_r[STAGES-1];
  assign z_out = z_r[STAGES-1];

endmodule

`default_nettype wire

### sv/geomagnetic_coordinate_transform_core.sv
// Top level of the geographic to geomagnetic coordinate transform.
// Depends on gct_pkg and gct_cordic.
`default_nettype none

// Usage
// A request is a geographic latitude and longitude in signed degrees with 16
// fraction bits. It is taken at a rising edge where start is high and busy is
// low; busy is always low, so a new request may be issued in every cycle.
// Each request produces exactly one result: out_valid is high for one cycle
// with the geomagnetic latitude, the longitude in 0 to 360 degrees and the
// pole flag. Results leave in request order and the receiver cannot hold them
// off, so nothing inside ever stalls.
// Throughput is one request per cycle. Each request passes in order through
// degree to binary-angle conversion, a rotation CORDIC, two rounds of Q30
// products, a 31-step integer square root and a vectoring CORDIC.
// The pole position lives in two configuration registers that are written
// through the cfg_ port; they must only change while no request is in flight.
// The pole terms travel down the same pipeline as every request.
// Reset clears the valid pipeline and loads the default pole; requests in
// flight at reset are dropped.

module geomagnetic_coordinate_transform_core
  #(
  parameter int CORDIC_STAGES = gct_pkg::CORDIC_STAGES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [gct_pkg::LAT_W-1:0]     in_geo_latitude,
  input  logic signed [gct_pkg::LON_W-1:0]     in_geo_longitude,
  output logic                                 out_valid,
  output logic signed [gct_pkg::LAT_W-1:0]     out_mag_latitude,
  output logic        [gct_pkg::LON_W-1:0]     out_mag_longitude,
  output logic                                 out_at_pole,
  input  logic                                 cfg_write_en,
  input  gct_pkg::cfg_index_t                  cfg_index,
  input  logic        [gct_pkg::CFG_W-1:0]     cfg_data
);
  import gct_pkg::*;

  localparam int LAT = 43 + 2 * CORDIC_STAGES;
  localparam int NL  = 4;

  // Lane order in the conversion stages.
  localparam int L_LAT  = 0;
  localparam int L_LON  = 1;
  localparam int L_PLAT = 2;
  localparam int L_PLON = 3;

  // ---------------------------------------------------------------------
  // Configuration registers and request valid pipeline.
  // ---------------------------------------------------------------------
  logic signed [LAT_W-1:0] pole_lat_r;
  logic signed [LON_W-1:0] pole_lon_r;
  logic [LAT-1:0]          vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_lat_r <= POLE_LAT_RESET;
      pole_lon_r <= POLE_LON_RESET;
      vld_r      <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_POLE_LAT: pole_lat_r <= cfg_data[LAT_W-1:0];
          CFG_POLE_LON: pole_lon_r <= cfg_data[LON_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy      = 1'b0;
  assign out_valid = vld_r[LAT-1];

  // ---------------------------------------------------------------------
  // Degrees to binary angle (2^32 per turn), rounded half away from zero.
  // q = floor((8192*|d| + 22) / 45), done as two reciprocal divisions by 45:
  // |d| = 45*q1 + r, then q = 8192*q1 + floor((8192*r + 22) / 45).
  // ---------------------------------------------------------------------
  logic signed [LON_W-1:0] raw_r   [NL];
  logic                    sgn1_r  [NL];
  logic [LON_W-1:0]        mag1_r  [NL];
  logic [50:0]             prod1_r [NL];
  logic                    sgn2_r  [NL];
  logic [19:0]             q1_2_r  [NL];
  logic [18:0]             x2_2_r  [NL];
  logic                    sgn3_r  [NL];
  logic [19:0]             q1_3_r  [NL];
  logic [18:0]             x2_3_r  [NL];
  logic [44:0]             prod2_r [NL];
  logic [31:0]             turn_r  [NL];

  logic [LON_W-1:0] mag_nxt   [NL];
  logic [50:0]      prod1_nxt [NL];
  logic [19:0]      q1_nxt    [NL];
  logic [18:0]      x2_nxt    [NL];
  logic [44:0]      prod2_nxt [NL];
  logic [31:0]      turn_nxt  [NL];

  always_comb begin
    logic [19:0] q1e;
    logic [25:0] rem1;
    logic [5:0]  rr;
    logic [13:0] q2e;
    logic [19:0] rem2;
    logic [13:0] q2;
    logic [32:0] qs;
    for (int l = 0; l < NL; l++) begin
      mag_nxt[l]   = raw_r[l][LON_W-1] ? LON_W'(-raw_r[l]) : LON_W'(raw_r[l]);
      prod1_nxt[l] = 51'(mag_nxt[l]) * 51'(RECIP_45);

      q1e  = prod1_r[l][50:31];
      rem1 = 26'(mag1_r[l]) - 26'(q1e) * 26'd45;
      if (rem1 >= 26'd45) begin
        q1_nxt[l] = q1e + 20'd1;
        rr        = 6'(rem1 - 26'd45);
      end else begin
        q1_nxt[l] = q1e;
        rr        = rem1[5:0];
      end
      x2_nxt[l]    = (19'(rr) << DEG_SHIFT) + DEG_ROUND;
      prod2_nxt[l] = 45'(x2_2_r[l]) * 45'(RECIP_45);

      q2e  = prod2_r[l][44:31];
      rem2 = 20'(x2_3_r[l]) - 20'(q2e) * 20'd45;
      q2   = (rem2 >= 20'd45) ? q2e + 14'd1 : q2e;
      qs   = (33'(q1_3_r[l]) << DEG_SHIFT) + 33'(q2);
      turn_nxt[l] = sgn3_r[l] ? -qs[31:0] : qs[31:0];
    end
  end

  always_ff @(posedge clk) begin
    raw_r[L_LAT]  <= LON_W'(in_geo_latitude);
    raw_r[L_LON]  <= in_geo_longitude;
    raw_r[L_PLAT] <= LON_W'(pole_lat_r);
    raw_r[L_PLON] <= pole_lon_r;
    for (int l = 0; l < NL; l++) begin
      sgn1_r[l]  <= raw_r[l][LON_W-1];
      mag1_r[l]  <= mag_nxt[l];
      prod1_r[l] <= prod1_nxt[l];
      sgn2_r[l]  <= sgn1_r[l];
      q1_2_r[l]  <= q1_nxt[l];
      x2_2_r[l]  <= x2_nxt[l];
      sgn3_r[l]  <= sgn2_r[l];
      q1_3_r[l]  <= q1_2_r[l];
      x2_3_r[l]  <= x2_2_r[l];
      prod2_r[l] <= prod2_nxt[l];
      turn_r[l]  <= turn_nxt[l];
    end
  end

  // ---------------------------------------------------------------------
  // Fold the three angles (latitude, pole latitude, longitude difference)
  // into +-90 degrees by a half turn; the flip negates sine and cosine.
  // ---------------------------------------------------------------------
  cword_t     z5_nxt [3];
  logic [2:0] flip5_nxt;
  cword_t     z5_r   [3];
  logic [2:0] flip5_r;

  always_comb begin
    logic [31:0] ang [3];
    cword_t      zs;
    ang[0] = turn_r[L_LAT];
    ang[1] = turn_r[L_PLAT];
    ang[2] = turn_r[L_LON] - turn_r[L_PLON];
    for (int k = 0; k < 3; k++) begin
      zs = CORDIC_W'($signed(ang[k]));
      if (zs > QUARTER) begin
        z5_nxt[k]    = zs - HALF;
        flip5_nxt[k] = 1'b1;
      end else if (zs < -QUARTER) begin
        z5_nxt[k]    = zs + HALF;
        flip5_nxt[k] = 1'b1;
      end else begin
        z5_nxt[k]    = zs;
        flip5_nxt[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    z5_r    <= z5_nxt;
    flip5_r <= flip5_nxt;
  end

  // Three rotation CORDICs: sin/cos of latitude, pole latitude, longitude difference.
  cword_t     rot_x [3];
  cword_t     rot_y [3];
  cword_t     rot_z [3];
  logic [2:0] flip_d_r [CORDIC_STAGES];

  for (genvar k = 0; k < 3; k++) begin : g_rot
    gct_cordic #(
      .STAGES    (CORDIC_STAGES),
      .VECTORING (1'b0)
    ) u_rot (
      .clk   (clk),
      .x_in  (CORDIC_GAIN),
      .y_in  ('0),
      .z_in  (z5_r[k]),
      .x_out (rot_x[k]),
      .y_out (rot_y[k]),
      .z_out (rot_z[k])
    );
  end

  always_ff @(posedge clk) begin
    flip_d_r[0] <= flip5_r;
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      flip_d_r[i] <= flip_d_r[i-1];
    end
  end

  // The residual angle of a rotation CORDIC is not needed.
  logic rot_z_unused;
  assign rot_z_unused = ^{rot_z[0], rot_z[1], rot_z[2]};

  // ---------------------------------------------------------------------
  // Sines and cosines, then the spherical rotation products in Q30.
  // ---------------------------------------------------------------------
  logic signed [31:0] sn_r [3];
  logic signed [31:0] cs_r [3];

  always_ff @(posedge clk) begin
    cword_t ny;
    cword_t nx;
    for (int k = 0; k < 3; k++) begin
      ny = -rot_y[k];
      nx = -rot_x[k];
      sn_r[k] <= flip_d_r[CORDIC_STAGES-1][k] ? ny[31:0] : rot_y[k][31:0];
      cs_r[k] <= flip_d_r[CORDIC_STAGES-1][k] ? nx[31:0] : rot_x[k][31:0];
    end
  end

  // Index 0 latitude (l), 1 pole latitude (p), 2 longitude difference (d).
  logic signed [31:0] m1_slsp_r, m1_clcp_r, m1_clcd_r, m1_ye_r, m1_cpsl_r;
  logic signed [31:0] m1_sp_r, m1_cd_r;

  always_ff @(posedge clk) begin
    m1_slsp_r <= mul_q30(sn_r[0], sn_r[1]);
    m1_clcp_r <= mul_q30(cs_r[0], cs_r[1]);
    m1_clcd_r <= mul_q30(cs_r[0], cs_r[2]);
    m1_ye_r   <= mul_q30(cs_r[0], sn_r[2]);
    m1_cpsl_r <= mul_q30(cs_r[1], sn_r[0]);
    m1_sp_r   <= sn_r[1];
    m1_cd_r   <= cs_r[2];
  end

  logic signed [31:0] m2_a_r, m2_b_r, m2_slsp_r, m2_cpsl_r, m2_ye_r;

  always_ff @(posedge clk) begin
    m2_a_r    <= mul_q30(m1_clcp_r, m1_cd_r);
    m2_b_r    <= mul_q30(m1_sp_r, m1_clcd_r);
    m2_slsp_r <= m1_slsp_r;
    m2_cpsl_r <= m1_cpsl_r;
    m2_ye_r   <= m1_ye_r;
  end

  // ---------------------------------------------------------------------
  // Sine of the magnetic latitude (clamped), the pole test, and the
  // longitude vector pre-rotated by a half turn when xe is negative.
  // The clamped sine spans -1.0 to +1.0 in Q30, so it needs 32 bits.
  // ---------------------------------------------------------------------
  logic signed [31:0] s_nxt;
  side_t              side_nxt;
  cword_t             lx_nxt, ly_nxt;
  logic signed [31:0] s3_r;
  side_t              side3_r;
  cword_t             lx3_r, ly3_r;

  always_comb begin
    logic signed [32:0] ssum;
    logic signed [32:0] xe;
    ssum = 33'(m2_slsp_r) + 33'(m2_a_r);
    if (ssum > 33'sd1073741824) begin
      s_nxt = 32'sd1073741824;
    end else if (ssum < -33'sd1073741824) begin
      s_nxt = -32'sd1073741824;
    end else begin
      s_nxt = ssum[31:0];
    end
    xe             = 33'(m2_b_r) - 33'(m2_cpsl_r);
    side_nxt.pole  = (s_nxt == 32'sd1073741824) || (s_nxt == -32'sd1073741824);
    side_nxt.degen = (xe == 33'sd0) && (m2_ye_r == 32'sd0);
    side_nxt.xneg  = xe[32];
    side_nxt.s_neg = s_nxt[31];
    lx_nxt = side_nxt.xneg ? -CORDIC_W'(xe) : CORDIC_W'(xe);
    ly_nxt = side_nxt.xneg ? -CORDIC_W'(m2_ye_r) : CORDIC_W'(m2_ye_r);
  end

  always_ff @(posedge clk) begin
    s3_r    <= s_nxt;
    side3_r <= side_nxt;
    lx3_r   <= lx_nxt;
    ly3_r   <= ly_nxt;
  end

  // 1 - s*s in Q60 for the cosine of the magnetic latitude.
  logic [61:0]        q_v_r;
  logic signed [31:0] q_s_r;
  side_t              q_side_r;
  cword_t             q_lx_r, q_ly_r;

  always_ff @(posedge clk) begin
    logic signed [61:0] sq;
    sq       = 62'(s3_r) * 62'(s3_r);
    q_v_r    <= (62'd1 << 60) - 62'(sq);
    q_s_r    <= s3_r;
    q_side_r <= side3_r;
    q_lx_r   <= lx3_r;
    q_ly_r   <= ly3_r;
  end

  // ---------------------------------------------------------------------
  // Integer square root, one result bit per stage, floor.
  // ---------------------------------------------------------------------
  logic [61:0]        sq_v_r    [SQRT_STEPS];
  logic [61:0]        sq_r_r    [SQRT_STEPS];
  logic signed [31:0] sq_s_r    [SQRT_STEPS];
  side_t              sq_side_r [SQRT_STEPS];
  cword_t             sq_lx_r   [SQRT_STEPS];
  cword_t             sq_ly_r   [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [61:0] SQ_BIT = 62'd1 << (2 * (SQRT_STEPS - 1 - j));
    logic [61:0]        v_in, r_in, v_nxt, r_nxt;
    logic signed [31:0] s_in;
    side_t              side_in;
    cword_t             lx_in, ly_in;

    if (j == 0) begin : g_first
      assign v_in    = q_v_r;
      assign r_in    = '0;
      assign s_in    = q_s_r;
      assign side_in = q_side_r;
      assign lx_in   = q_lx_r;
      assign ly_in   = q_ly_r;
    end else begin : g_next
      assign v_in    = sq_v_r[j-1];
      assign r_in    = sq_r_r[j-1];
      assign s_in    = sq_s_r[j-1];
      assign side_in = sq_side_r[j-1];
      assign lx_in   = sq_lx_r[j-1];
      assign ly_in   = sq_ly_r[j-1];
    end

    always_comb begin
      logic [61:0] trial;
      trial = r_in + SQ_BIT;
      if (v_in >= trial) begin
        v_nxt = v_in - trial;
        r_nxt = (r_in >> 1) + SQ_BIT;
      end else begin
        v_nxt = v_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      sq_v_r[j]    <= v_nxt;
      sq_r_r[j]    <= r_nxt;
      sq_s_r[j]    <= s_in;
      sq_side_r[j] <= side_in;
      sq_lx_r[j]   <= lx_in;
      sq_ly_r[j]   <= ly_in;
    end
  end

  // The remainder of the last root step is not needed.
  logic sq_v_unused;
  assign sq_v_unused = ^sq_v_r[SQRT_STEPS-1];

  // ---------------------------------------------------------------------
  // Two vectoring CORDICs side by side: latitude from (cos, sin) and
  // longitude from the (possibly pre-rotated) (xe, ye) vector.
  // ---------------------------------------------------------------------
  cword_t lat_x_in, lat_y_in;
  cword_t vlat_x, vlat_y, vlat_z;
  cword_t vlon_x, vlon_y, vlon_z;
  side_t  vside_r [CORDIC_STAGES];

  assign lat_x_in = CORDIC_W'(sq_r_r[SQRT_STEPS-1][30:0]);
  assign lat_y_in = CORDIC_W'(sq_s_r[SQRT_STEPS-1]);

  gct_cordic #(
    .STAGES    (CORDIC_STAGES),
    .VECTORING (1'b1)
  ) u_vec_lat (
    .clk   (clk),
    .x_in  (lat_x_in),
    .y_in  (lat_y_in),
    .z_in  ('0),
    .x_out (vlat_x),
    .y_out (vlat_y),
    .z_out (vlat_z)
  );

  gct_cordic #(
    .STAGES    (CORDIC_STAGES),
    .VECTORING (1'b1)
  ) u_vec_lon (
    .clk   (clk),
    .x_in  (sq_lx_r[SQRT_STEPS-1]),
    .y_in  (sq_ly_r[SQRT_STEPS-1]),
    .z_in  ('0),
    .x_out (vlon_x),
    .y_out (vlon_y),
    .z_out (vlon_z)
  );

  always_ff @(posedge clk) begin
    vside_r[0] <= sq_side_r[SQRT_STEPS-1];
    for (int i = 1; i < CORDIC_STAGES; i++) begin
      vside_r[i] <= vside_r[i-1];
    end
  end

  // Only the angle of a vectoring CORDIC is used.
  logic vec_xy_unused;
  assign vec_xy_unused = ^{vlat_x, vlat_y, vlon_x, vlon_y};

  // ---------------------------------------------------------------------
  // Binary angle back to degrees, clamping, and the output register.
  // At the pole the latitude is exactly +-90 and the longitude 0; a zero
  // (xe, ye) vector also reports longitude 0.
  // ---------------------------------------------------------------------
  side_t                   oside;
  logic signed [LAT_W-1:0] mlat_nxt;
  logic [LON_W-1:0]        mlon_nxt;

  assign oside = vside_r[CORDIC_STAGES-1];

  always_comb begin
    cword_t             zlat;
    logic signed [44:0] lt;
    logic signed [28:0] ml;
    logic [31:0]        zl;
    logic [40:0]        lp;
    if (oside.pole) begin
      zlat = oside.s_neg ? -QUARTER : QUARTER;
    end else begin
      zlat = vlat_z;
    end
    lt = 45'(zlat) * 45'sd360 + 45'sd32768;
    ml = lt[44:16];
    if (ml > MLAT_LIM) begin
      mlat_nxt = LAT_W'(MLAT_LIM);
    end else if (ml < -MLAT_LIM) begin
      mlat_nxt = LAT_W'(-MLAT_LIM);
    end else begin
      mlat_nxt = ml[LAT_W-1:0];
    end

    zl = oside.xneg ? vlon_z[31:0] + 32'h8000_0000 : vlon_z[31:0];
    lp = 41'(zl) * 41'd360 + 41'd32768;
    if (oside.pole || oside.degen) begin
      mlon_nxt = '0;
    end else if (lp[40:16] > MLON_LIM) begin
      mlon_nxt = MLON_LIM;
    end else begin
      mlon_nxt = lp[40:16];
    end
  end

  always_ff @(posedge clk) begin
    out_mag_latitude  <= mlat_nxt;
    out_mag_longitude <= mlon_nxt;
    out_at_pole       <= oside.pole;
  end

  // ---------------------------------------------------------------------
  // Checks on the result path.
  // ---------------------------------------------------------------------
  a_pole_lon_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_pole |-> out_mag_longitude == '0)
    else $error("pole result with nonzero longitude");

  a_pole_lat_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_pole |->
      (out_mag_latitude == LAT_W'(MLAT_LIM)) || (out_mag_latitude == LAT_W'(-MLAT_LIM)))
    else $error("pole result without a full latitude");

  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mag_latitude <= LAT_W'(MLAT_LIM)) &&
                  (out_mag_latitude >= LAT_W'(-MLAT_LIM)))
    else $error("latitude outside +-90 degrees");

  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mag_longitude <= MLON_LIM)
    else $error("longitude beyond 360 degrees");

endmodule

`default_nettype wire

### tb/geomagnetic_coordinate_transform_core_tb.sv
// Self-checking testbench for geomagnetic_coordinate_transform_core.
// Drives random and directed coordinate requests against a bit-exact CORDIC predictor.
// Depends on gct_pkg and the core RTL only.
`timescale 1ns / 100ps

module geomagnetic_coordinate_transform_core_tb;
  import gct_pkg::*;

  // Result of one coordinate transform as the core should report it.
  typedef struct packed {
    logic [LAT_W-1:0] mag_lat;
    logic [LON_W-1:0] mag_lon;
    logic             pole;
  } mag_point_t;

  // One geographic request waiting to be issued.
  typedef struct packed {
    logic [LAT_W-1:0] lat;
    logic [LON_W-1:0] lon;
  } geo_point_t;

  localparam int  PIPE_LATENCY = 43 + 2 * CORDIC_STAGES;
  localparam int  DRAIN_WAIT   = PIPE_LATENCY + 20;
  localparam int  STALL_LIMIT  = 4000;
  localparam int  LAT_90       = 5898240;
  localparam int  LON_180      = 11796480;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [LAT_W-1:0] in_geo_latitude;
  logic signed [LON_W-1:0] in_geo_longitude;
  logic                    out_valid;
  logic signed [LAT_W-1:0] out_mag_latitude;
  logic        [LON_W-1:0] out_mag_longitude;
  logic                    out_at_pole;
  logic                    cfg_write_en;
  cfg_index_t              cfg_index;
  logic        [CFG_W-1:0] cfg_data;

  geo_point_t  pending_points[$];
  mag_point_t  expected_points[$];
  logic [LAT_W-1:0] pole_lat_q;
  logic [LON_W-1:0] pole_lon_q;
  int          mismatch_count;
  int          stall_cycles;
  int          issue_gap;
  bit          burst_mode;
  int          burst_left;

  // The arctangent table of the rotation stages, in binary angle units.
  longint atan_lut[32] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                           10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                           83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                           81, 41, 20, 10, 5, 3, 1, 1, 0};

  geomagnetic_coordinate_transform_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_geo_latitude(in_geo_latitude), .in_geo_longitude(in_geo_longitude),
    .out_valid(out_valid), .out_mag_latitude(out_mag_latitude),
    .out_mag_longitude(out_mag_longitude), .out_at_pole(out_at_pole),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Q30 product rounded half up; the arithmetic shift floors.
  function automatic longint q30_mult(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Degrees with 16 fraction bits to a binary angle, rounded half away from zero.
  function automatic logic [31:0] deg_to_bam(longint d);
    longint v;
    longint q;
    v = d * 65536;
    q = (v >= 0) ? (v + 180) / 360 : -((180 - v) / 360);
    return q[31:0];
  endfunction

  function automatic void bam_sincos(input logic [31:0] ang, output longint sn,
                                     output longint cs);
    longint z;
    longint x;
    longint y;
    longint nx;
    bit     flip;
    z = ang[31] ? longint'(ang) - (64'sd1 <<< 32) : longint'(ang);
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > (64'sd1 <<< 30)) begin
      z = z - (64'sd1 <<< 31);
      flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z = z + (64'sd1 <<< 31);
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i % 32];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i % 32];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // Vectoring CORDIC: angle of (x, y) with x >= 0, signed binary angle.
  function automatic longint vector_bam(longint x, longint y);
    longint z;
    longint nx;
    z = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + atan_lut[i % 32];
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - atan_lut[i % 32];
      end
      x = nx;
    end
    return z;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Rotates one geographic point about the configured pole.
  function automatic mag_point_t rotate_to_magnetic(logic signed [LAT_W-1:0] lat,
                                                    logic signed [LON_W-1:0] lon);
    mag_point_t  res;
    logic [31:0] dlon;
    logic [31:0] zl;
    logic [63:0] mlon;
    longint      sl, cl, sp, cp, sd, cd, s, xe, ye, c, zlat, mlat;
    bit          pole;
    dlon = deg_to_bam(longint'(lon)) - deg_to_bam(longint'($signed(pole_lon_q)));
    bam_sincos(deg_to_bam(longint'(lat)), sl, cl);
    bam_sincos(deg_to_bam(longint'($signed(pole_lat_q))), sp, cp);
    bam_sincos(dlon, sd, cd);
    s = q30_mult(sl, sp) + q30_mult(q30_mult(cl, cp), cd);
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
    xe = q30_mult(sp, q30_mult(cl, cd)) - q30_mult(cp, sl);
    ye = q30_mult(cl, sd);
    pole = (s == (64'sd1 <<< 30)) || (s == -(64'sd1 <<< 30));
    mlon = 0;
    if (pole) begin
      zlat = (s > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
    end else begin
      c = longint'(floor_sqrt((64'd1 << 60) - 64'(s * s)));
      zlat = vector_bam(c, s);
    end
    if (!pole && (xe != 0 || ye != 0)) begin
      if (xe < 0) zl = 32'h8000_0000 + 32'(vector_bam(-xe, -ye));
      else zl = 32'(vector_bam(xe, ye));
      mlon = (64'(zl) * 360 + 64'd32768) >> 16;
      if (mlon > 64'd23592960) mlon = 64'd23592960;
    end
    mlat = (zlat * 360 + 64'sd32768) >>> 16;
    if (mlat > LAT_90) mlat = LAT_90;
    if (mlat < -LAT_90) mlat = -LAT_90;
    res.mag_lat = mlat[LAT_W-1:0];
    res.mag_lon = mlon[LON_W-1:0];
    res.pole = pole;
    return res;
  endfunction

  // Driver: issues queued requests with random gaps, and predicts each one that
  // the core accepts. All next values are settled first so that every signal gets
  // at most one nonblocking assignment per edge.
  always @(posedge clk) begin
    geo_point_t nxt;
    logic       nxt_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(rotate_to_magnetic(in_geo_latitude, in_geo_longitude));
      end
      nxt_start = 1'b0;
      nxt = '0;
      if (start && busy) begin
        // The request has not been taken yet, so it stays on the bus.
        nxt_start = 1'b1;
        nxt.lat = in_geo_latitude;
        nxt.lon = in_geo_longitude;
      end else if (issue_gap > 0) begin
        issue_gap <= issue_gap - 1;
      end else if (pending_points.size() > 0) begin
        nxt = pending_points.pop_front();
        nxt_start = 1'b1;
        // Switch at random between back-to-back bursts and spells with idle cycles.
        if (burst_left == 0) begin
          burst_mode = ($urandom_range(0, 2) == 0);
          burst_left = $urandom_range(20, 150);
        end else begin
          burst_left = burst_left - 1;
        end
        if (burst_mode) issue_gap <= 0;
        else if ($urandom_range(0, 19) == 0) issue_gap <= $urandom_range(10, 60);
        else issue_gap <= $urandom_range(0, 3);
      end
      start <= nxt_start;
      if (nxt_start) begin
        in_geo_latitude <= nxt.lat;
        in_geo_longitude <= nxt.lon;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    mag_point_t exp_pt;
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("ERROR: result with no request in flight");
      end else begin
        exp_pt = expected_points.pop_front();
        if (exp_pt.mag_lat !== out_mag_latitude || exp_pt.mag_lon !== out_mag_longitude ||
            exp_pt.pole !== out_at_pole) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("ERROR: expected lat %0d lon %0d pole %0b, got lat %0d lon %0d pole %0b",
                     $signed(exp_pt.mag_lat), exp_pt.mag_lon, exp_pt.pole,
                     out_mag_latitude, out_mag_longitude, out_at_pole);
        end
      end
    end
  end

  // Watchdog: a run where nothing moves for too long has hung.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic int rand_lat();
    return int'($urandom_range(0, 2 * LAT_90)) - LAT_90;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(0, 2 * LON_180)) - LON_180;
  endfunction

  task automatic queue_point(int lat, int lon);
    geo_point_t p;
    p.lat = lat[LAT_W-1:0];
    p.lon = lon[LON_W-1:0];
    pending_points.push_back(p);
  endtask

  // Waits until every request has come back and the pipeline has drained.
  task automatic wait_idle();
    while (pending_points.size() > 0 || start || expected_points.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Writes both pole registers; only called while the core is idle.
  task automatic set_pole(int lat, int lon);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_POLE_LAT;
    cfg_data <= CFG_W'(lat);
    @(posedge clk);
    pole_lat_q = lat[LAT_W-1:0];
    cfg_index <= CFG_POLE_LON;
    cfg_data <= CFG_W'(lon);
    @(posedge clk);
    pole_lon_q = lon[LON_W-1:0];
    cfg_write_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random requests: mostly in range, some near the pole or its antipode, a few
  // at exactly ninety degrees and a few using the whole field width.
  task automatic queue_random(int count);
    int kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 19);
      if (kind < 12) begin
        queue_point(rand_lat(), rand_lon());
      end else if (kind < 15) begin
        queue_point(int'($signed(pole_lat_q)) + int'($urandom_range(0, 64)) - 32,
                    int'($signed(pole_lon_q)) + int'($urandom_range(0, 64)) - 32);
      end else if (kind < 16) begin
        queue_point(-int'($signed(pole_lat_q)) + int'($urandom_range(0, 8)) - 4,
                    int'($signed(pole_lon_q)) + LON_180);
      end else if (kind < 18) begin
        queue_point($urandom_range(0, 1) ? LAT_90 : -LAT_90, rand_lon());
      end else begin
        queue_point(int'($urandom()), int'($urandom()));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_geo_latitude = '0;
    in_geo_longitude = '0;
    cfg_write_en = 1'b0;
    cfg_index = CFG_POLE_LAT;
    cfg_data = '0;
    pole_lat_q = POLE_LAT_RESET;
    pole_lon_q = POLE_LON_RESET;
    mismatch_count = 0;
    stall_cycles = 0;
    issue_gap = 0;
    burst_mode = 1'b0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with the reset pole: field extremes, both poles of the
    // globe, the magnetic pole itself (latitude cosine of zero), its antipode,
    // and values outside the stated ranges that must wrap.
    queue_point(0, 0);
    queue_point(LAT_90, 0);
    queue_point(-LAT_90, 0);
    queue_point(0, LON_180);
    queue_point(0, -LON_180);
    queue_point(LAT_90, LON_180);
    queue_point(-LAT_90, -LON_180);
    queue_point(int'(POLE_LAT_RESET), int'(POLE_LON_RESET));
    queue_point(-int'(POLE_LAT_RESET), int'(POLE_LON_RESET) + LON_180);
    queue_point(int'(POLE_LAT_RESET) + 1, int'(POLE_LON_RESET));
    queue_point(-8388608, -16777216);
    queue_point(8388607, 16777215);
    queue_point(1, -1);
    queue_point(-1, 1);
    wait_idle();

    // A pole on the geographic pole: every longitude lies on a meridian, and
    // a point on that pole is at the magnetic pole.
    set_pole(LAT_90, 0);
    queue_point(LAT_90, 0);
    queue_point(LAT_90, 12345);
    queue_point(-LAT_90, 0);
    queue_point(0, 0);
    queue_point(0, -LON_180);
    queue_random(300);
    wait_idle();

    set_pole(-LAT_90, -LON_180);
    queue_point(-LAT_90, -LON_180);
    queue_point(LAT_90, LON_180);
    queue_random(300);
    wait_idle();

    set_pole(0, LON_180);
    queue_point(0, LON_180);
    queue_point(0, 0);
    queue_random(300);
    wait_idle();

    set_pole(8388607, -16777216);
    queue_random(150);
    wait_idle();

    set_pole(rand_lat(), rand_lon());
    queue_random(300);
    wait_idle();

    set_pole(int'(POLE_LAT_RESET), int'(POLE_LON_RESET));
    queue_random(530);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
sv/gct_pkg.sv
sv/gct_cordic.sv
sv/geomagnetic_coordinate_transform_core.sv
tb/geomagnetic_coordinate_transform_core_tb.sv
